>>> hdl/srt_pkg.sv
// shared constants, types and neighbor tables for the river tracer
`default_nettype none
package srt_pkg;

	localparam int MAX_GRID_X = 64;
	localparam int MAX_GRID_Y = 64;
	localparam int MAX_STEPS  = 30;

	localparam int X_W    = $clog2(MAX_GRID_X);
	localparam int Y_W    = $clog2(MAX_GRID_Y);
	localparam int DIM_W  = 7;
	localparam int H_W    = 16;
	localparam int ADDR_W = 12;
	localparam int DEPTH  = MAX_GRID_X * MAX_GRID_Y;
	localparam int IDX_W  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

	localparam logic [DIM_W-1:0] GRID_X_MAX = DIM_W'(MAX_GRID_X);
	localparam logic [DIM_W-1:0] GRID_Y_MAX = DIM_W'(MAX_GRID_Y);

	typedef enum logic [1:0] {
		REG_GRID_W = 2'd0,
		REG_GRID_H = 2'd1,
		REG_THRESH = 2'd2
	} reg_idx_t;

	// effective configuration, dimensions already clamped
	typedef struct packed {
		logic [DIM_W-1:0] gw;
		logic [DIM_W-1:0] gh;
		logic [H_W-1:0]   thr;
	} cfg_t;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
		logic [H_W-1:0] h;
	} point_t;

	// neighbor scan order: dx outer, dy inner, slot 4 is the center
	function automatic logic signed [1:0] nb_dx(input logic [3:0] s);
		logic signed [1:0] d;
		unique case (s)
			4'd0, 4'd1, 4'd2: d = -2'sd1;
			4'd6, 4'd7, 4'd8: d = 2'sd1;
			default:          d = 2'sd0;
		endcase
		return d;
	endfunction

	function automatic logic signed [1:0] nb_dy(input logic [3:0] s);
		logic signed [1:0] d;
		unique case (s)
			4'd0, 4'd3, 4'd6: d = -2'sd1;
			4'd2, 4'd5, 4'd8: d = 2'sd1;
			default:          d = 2'sd0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

>>> hdl/srt_height_ram.sv
// height store: one write port, one registered read port
`default_nettype none
module srt_height_ram (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [srt_pkg::ADDR_W-1:0] waddr,
	input  wire logic [srt_pkg::H_W-1:0]    wdata,
	input  wire logic [srt_pkg::ADDR_W-1:0] raddr,
	output logic      [srt_pkg::H_W-1:0]    rdata
);
	import srt_pkg::*;

	logic [H_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> hdl/srt_walker.sv
// trace sequencer: start decode, neighbor compare unit, path buffer, point output
`default_nettype none
module srt_walker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire srt_pkg::cfg_t              cfg,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       action,
	input  wire logic [srt_pkg::ADDR_W-1:0] cell_index,
	output logic      [srt_pkg::ADDR_W-1:0] rd_addr,
	input  wire logic [srt_pkg::H_W-1:0]    rd_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [5:0]                 point_x,
	output logic      [5:0]                 point_y,
	output logic      [15:0]                point_height,
	output logic                            last_point
);
	import srt_pkg::*;

	localparam logic [3:0] NB_CENTER = 4'd4;
	localparam logic [3:0] NB_LAST   = 4'd8;
	localparam logic [3:0] NB_DONE   = 4'd9;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DIV    = 6'b000010,
		ST_START  = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_DECIDE = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [ADDR_W-1:0]   rem_q;
	logic [X_W-1:0]      quo_q;
	logic [X_W-1:0]      cur_x_q;
	logic [Y_W-1:0]      cur_y_q;
	point_t              best_q;
	logic                found_q;
	logic [3:0]          scan_q;
	logic [IDX_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    k_q;
	logic                rd_vld_s1;
	logic [X_W-1:0]      nb_x_s1;
	logic [Y_W-1:0]      nb_y_s1;
	logic                out_valid_q;
	point_t              out_pt_q;
	logic                out_last_q;
	point_t              path_q [MAX_STEPS];

	logic signed [1:0]   dx, dy;
	logic signed [7:0]   nx, ny;
	logic                nb_ok;
	logic [12:0]         nb_prod;
	logic [ADDR_W-1:0]   nb_addr;
	logic                take_trace;
	logic                out_free;
	logic                better;
	logic                start_ok;
	logic                stop_walk;
	logic                buf_we;
	logic [IDX_W-1:0]    buf_wi;
	point_t              buf_wd;
	point_t              emit_pt;
	logic                emit_last;

	always_comb begin
		dx = nb_dx(scan_q);
		dy = nb_dy(scan_q);
		nx = signed'({{(8-X_W){1'b0}}, cur_x_q}) + {{6{dx[1]}}, dx};
		ny = signed'({{(8-Y_W){1'b0}}, cur_y_q}) + {{6{dy[1]}}, dy};
		nb_ok = (scan_q != NB_CENTER) && (scan_q <= NB_LAST)
			&& !nx[7] && (nx < signed'({1'b0, cfg.gw}))
			&& !ny[7] && (ny < signed'({1'b0, cfg.gh}));
		nb_prod = 13'(nx[X_W-1:0]) * 13'(cfg.gh);
		nb_addr = ADDR_W'(nb_prod + 13'(ny[Y_W-1:0]));
		rd_addr = (state_q == ST_DIV) ? idx_q : nb_addr;
	end

	assign take_trace = in_valid && (state_q == ST_IDLE) && action;
	assign out_free   = !out_valid_q || !out_stall;
	assign better     = rd_vld_s1 && (rd_data < best_q.h);
	assign start_ok   = rd_data > cfg.thr;
	assign stop_walk  = !found_q || (cnt_q == IDX_W'(MAX_STEPS - 1));
	assign emit_pt    = path_q[k_q];
	assign emit_last  = (k_q == cnt_q);

	// path buffer write: start cell, then each winner
	always_comb begin
		buf_we = 1'b0;
		buf_wi = cnt_q + IDX_W'(1);
		buf_wd = best_q;
		if (state_q == ST_START) begin
			buf_we = start_ok;
			buf_wi = '0;
			buf_wd = '{x: cur_x_q, y: cur_y_q, h: rd_data};
		end else if (state_q == ST_DECIDE) begin
			buf_we = !stop_walk;
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			path_q[buf_wi] <= buf_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			scan_q      <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			rd_vld_s1   <= 1'b0;
			nb_x_s1     <= '0;
			nb_y_s1     <= '0;
			out_valid_q <= 1'b0;
			out_pt_q    <= '0;
			out_last_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take_trace) begin
						idx_q   <= cell_index;
						rem_q   <= cell_index;
						quo_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// column by repeated subtraction; running past the last column means off grid
					if (rem_q >= ADDR_W'(cfg.gh)) begin
						if (quo_q == X_W'(cfg.gw - DIM_W'(1))) begin
							state_q <= ST_IDLE;
						end else begin
							rem_q <= rem_q - ADDR_W'(cfg.gh);
							quo_q <= quo_q + X_W'(1);
						end
					end else begin
						cur_x_q <= quo_q;
						cur_y_q <= rem_q[Y_W-1:0];
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (start_ok) begin
						best_q  <= '{x: cur_x_q, y: cur_y_q, h: rd_data};
						found_q <= 1'b0;
						scan_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					// issue one neighbor read per cycle, compare the one read last cycle
					if (scan_q != NB_DONE) begin
						rd_vld_s1 <= nb_ok;
						nb_x_s1   <= nx[X_W-1:0];
						nb_y_s1   <= ny[Y_W-1:0];
						scan_q    <= scan_q + 4'd1;
					end else begin
						state_q <= ST_DECIDE;
					end
					if (better) begin
						best_q  <= '{x: nb_x_s1, y: nb_y_s1, h: rd_data};
						found_q <= 1'b1;
					end
				end
				ST_DECIDE: begin
					if (stop_walk) begin
						k_q <= '0;
						if (cnt_q == '0 || cnt_q == IDX_W'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT;
						end
					end else begin
						cnt_q   <= cnt_q + IDX_W'(1);
						cur_x_q <= best_q.x;
						cur_y_q <= best_q.y;
						found_q <= 1'b0;
						scan_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_pt_q    <= emit_pt;
						out_last_q  <= emit_last;
						k_q         <= k_q + IDX_W'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign point_x      = 6'(out_pt_q.x);
	assign point_y      = 6'(out_pt_q.y);
	assign point_height = out_pt_q.h;
	assign last_point   = out_last_q;

endmodule
`default_nettype wire

>>> hdl/steepest_descent_river_tracer.sv
// river tracer top level: configuration registers, height store and walk sequencer
//
// input channel (in_valid / in_stall): one word per load or trace request.
// a load (action 0) writes cell_height at cell_index and leaves in_stall low.
// a trace (action 1) holds in_stall high until its whole path is handed to
// the output register; a path of fewer than three points is not sent. the
// start index is split into column and row by repeated subtraction of the
// row count, and each walk step (up to 30) makes one read and one compare
// per neighbor through the single read port of the height store.
// output channel (out_valid / out_stall): one word per path point, last_point
// on the final one; a stalled word holds and the walk waits for it.
// configuration (cfg_valid / cfg_ready): always ready, index 0 width,
// 1 height, 2 threshold; write only while idle.
// reset clears the sequencer, the output register and the configuration to
// 64 x 64 with threshold 52429; the height store is not cleared and every
// cell must be loaded before a trace reads it.
`default_nettype none
module steepest_descent_river_tracer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [11:0] cell_index,
	input  wire logic [15:0] cell_height,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [5:0]  point_x,
	output logic      [5:0]  point_y,
	output logic      [15:0] point_height,
	output logic             last_point,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import srt_pkg::*;

	logic [DIM_W-1:0]  grid_w_q;
	logic [DIM_W-1:0]  grid_h_q;
	logic [H_W-1:0]    thresh_q;
	cfg_t              cfg;
	logic              ram_we;
	logic [ADDR_W-1:0] rd_addr;
	logic [H_W-1:0]    rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= DIM_W'(64);
			grid_h_q <= DIM_W'(64);
			thresh_q <= 16'd52429;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GRID_W: grid_w_q <= cfg_data[DIM_W-1:0];
				REG_GRID_H: grid_h_q <= cfg_data[DIM_W-1:0];
				REG_THRESH: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, anything past the grid maximum acts as the maximum
	always_comb begin
		cfg.gw  = (grid_w_q == '0) ? DIM_W'(1)
			: ((grid_w_q > GRID_X_MAX) ? GRID_X_MAX : grid_w_q);
		cfg.gh  = (grid_h_q == '0) ? DIM_W'(1)
			: ((grid_h_q > GRID_Y_MAX) ? GRID_Y_MAX : grid_h_q);
		cfg.thr = thresh_q;
	end

	assign ram_we = in_valid && !in_stall && !action;

	srt_height_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cell_index),
		.wdata (cell_height),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	srt_walker u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.cell_index   (cell_index),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_height (point_height),
		.last_point   (last_point)
	);

endmodule
`default_nettype wire

>>> hdl/srt_checker.sv
// port-level checks for the river tracer, bound to the top level
`default_nettype none
module srt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        action,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [5:0]  point_x,
	input wire logic [5:0]  point_y,
	input wire logic [15:0] point_height,
	input wire logic        last_point
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
			&& $stable(point_height) && $stable(last_point))
		else $error("stalled output word changed");

	// a trace keeps the input side busy on the following cycle
	a_trace_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action |=> in_stall)
		else $error("input not stalled after trace request");

	// a load does not stall the input side
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !action |=> !in_stall)
		else $error("input stalled after load");

	// points of one path follow without gaps
	a_path_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_point |=> out_valid)
		else $error("gap inside a path");

	// nothing directly follows the final point
	a_path_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_point |=> !out_valid)
		else $error("word right after final point");

endmodule

bind steepest_descent_river_tracer srt_checker u_srt_checker (.*);
`default_nettype wire
